FILE: sv/audio_category_gain_and_voice_admit_unit_macros.svh
// assertion macros for the category gain unit checker
// no dependencies
`ifndef AUDIO_CATEGORY_GAIN_AND_VOICE_ADMIT_UNIT_MACROS_SVH
`define AUDIO_CATEGORY_GAIN_AND_VOICE_ADMIT_UNIT_MACROS_SVH
`define ACG_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define ACG_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

FILE: sv/acg_pkg.sv
// types, codes and constants for the category gain unit
// no dependencies
`timescale 1ns / 1ps
package acg_pkg;
  localparam int NUM_CATEGORIES_DEF = 16;
  localparam logic [15:0] UNITY = 16'd32768;

  typedef enum logic [3:0] {
    OP_TICK = 4'd0, OP_SET_VOL = 4'd1, OP_FADE = 4'd2, OP_MUTE = 4'd3,
    OP_SOLO = 4'd4, OP_PAUSE = 4'd5, OP_ADMIT = 4'd6, OP_VSTART = 4'd7,
    OP_VEND = 4'd8, OP_LIMIT = 4'd9
  } op_t;

  localparam logic REG_MASTER = 1'b0;
  localparam logic REG_FLOOR = 1'b1;

  typedef struct packed {
    logic [3:0]  operation;
    logic [3:0]  category;
    logic [15:0] level;
    logic [15:0] duration_ticks;
    logic        flag;
    logic [7:0]  priority_req;
    logic [7:0]  new_limit;
  } in_t;

  typedef struct packed {
    logic [3:0]  out_category;
    logic [15:0] effective_gain;
    logic [15:0] base_gain;
    logic [7:0]  voices_active;
    logic        granted;
    logic [11:0] total_voices;
    logic        solo_active;
    logic        last;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE, S_OP, S_TMUL, S_TDIV, S_TEFF, S_SUM, S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic do_op;
    logic tick_mul;
    logic div_start;
    logic tick_eff;
    logic sum_step;
    logic emit;
    logic clr_idx;
    logic inc_idx;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic idx_last;
    logic div_busy;
  } sts_t;

  function automatic logic [7:0] limit_reset(input int k);
    logic [7:0] r;
    unique case (k)
      0: r = 8'd2;
      1: r = 8'd16;
      2: r = 8'd8;
      3: r = 8'd12;
      4: r = 8'd8;
      5: r = 8'd6;
      6: r = 8'd4;
      7: r = 8'd16;
      8: r = 8'd2;
      default: r = 8'd8;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] clamp16(input logic [15:0] v);
    return (v > UNITY) ? UNITY : v;
  endfunction
endpackage

FILE: sv/acg_div.sv
// restoring divider, one quotient bit per cycle, magnitude 32 by 16
// depends on acg_pkg
`timescale 1ns / 1ps
module acg_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);
  import acg_pkg::*;
  logic [5:0]  cnt;
  logic [16:0] rem;
  logic [31:0] q;
  logic [15:0] dv;
  logic [16:0] trial;

  assign trial = {rem[15:0], q[31]};
  assign busy = (cnt != 6'd0);
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 6'd0;
    end else if (start) begin
      cnt <= 6'd32;
      rem <= 17'd0;
      q <= dividend;
      dv <= divisor;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (trial >= {1'b0, dv}) begin
        rem <= trial - {1'b0, dv};
        q <= {q[30:0], 1'b1};
      end else begin
        rem <= trial;
        q <= {q[30:0], 1'b0};
      end
    end
  end
endmodule

FILE: sv/acg_datapath.sv
// category state table, operation logic, fade and gain arithmetic
// depends on acg_pkg and acg_div
`timescale 1ns / 1ps
module acg_datapath #(
  parameter int NUM_CATEGORIES = acg_pkg::NUM_CATEGORIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  acg_pkg::cmd_t    cmd,
  output acg_pkg::sts_t    sts,
  input  acg_pkg::in_t     in_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_data,
  output acg_pkg::out_t    out_data
);
  import acg_pkg::*;
  localparam int N = NUM_CATEGORIES;

  logic [15:0] base [N];
  logic [15:0] tgt [N];
  logic [15:0] eff [N];
  logic [15:0] elap [N];
  logic [15:0] flen [N];
  logic [7:0]  vlim [N];
  logic [7:0]  vcnt [N];
  logic [N-1:0] muted, soloed, paused;
  logic [15:0] master;
  logic [7:0]  pfloor;
  in_t         it;
  logic        grant;
  logic [4:0]  idx;
  logic [3:0]  ki;
  logic [11:0] total;
  logic        neg;
  logic [31:0] prod;
  logic [31:0] gprod;
  logic        fade_on;
  logic        div_busy;
  logic [31:0] quo;
  logic        hit;
  logic [3:0]  c;
  logic [15:0] lvl;
  logic        eff_pend;
  logic [3:0]  eidx;

  assign ki = idx[3:0];
  assign c = it.category;
  assign hit = ({1'b0, c} < 5'(N));
  assign lvl = clamp16(it.level);

  acg_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(prod),
    .divisor(flen[ki]), .busy(div_busy), .quotient(quo)
  );

  assign sts.is_tick = (it.operation == OP_TICK);
  assign sts.idx_last = (idx == 5'(N - 1));
  assign sts.div_busy = div_busy;

  logic [15:0] e1;
  logic        fdone;
  logic [16:0] nb;
  always_comb begin
    e1 = elap[ki] + 16'd1;
    fdone = (e1 >= flen[ki]);
    nb = neg ? ({1'b0, base[ki]} - quo[16:0]) : ({1'b0, base[ki]} + quo[16:0]);
  end

  // effective gain of the category whose fade was just updated
  always_comb begin
    gprod = 32'(base[eidx]) * 32'(master);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      master <= UNITY;
      pfloor <= 8'd0;
      muted <= '0;
      soloed <= '0;
      paused <= '0;
      idx <= '0;
      eff_pend <= 1'b0;
      eidx <= 4'd0;
      for (int k = 0; k < N; k++) begin
        base[k] <= UNITY;
        tgt[k] <= UNITY;
        eff[k] <= UNITY;
        elap[k] <= 16'd0;
        flen[k] <= 16'd0;
        vlim[k] <= limit_reset(k);
        vcnt[k] <= 8'd0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MASTER) master <= clamp16(cfg_data);
        else pfloor <= cfg_data[7:0];
      end
      if (cmd.load) begin
        it <= in_data;
        grant <= 1'b0;
      end
      if (cmd.clr_idx) idx <= '0;
      else if (cmd.inc_idx) idx <= idx + 5'd1;
      if (cmd.do_op && hit) begin
        unique case (it.operation)
          OP_SET_VOL: begin
            base[c] <= lvl; tgt[c] <= lvl; flen[c] <= 16'd0;
          end
          OP_FADE: begin
            tgt[c] <= lvl; flen[c] <= it.duration_ticks; elap[c] <= 16'd0;
          end
          OP_MUTE: muted[c] <= it.flag;
          OP_SOLO: begin
            if (it.flag) soloed <= N'(1) << c;
            else soloed[c] <= 1'b0;
          end
          OP_PAUSE: paused[c] <= it.flag;
          OP_ADMIT: grant <= (vcnt[c] < vlim[c]) && (it.priority_req >= pfloor)
                             && !muted[c] && !paused[c];
          OP_VSTART: if (vcnt[c] != 8'd255) vcnt[c] <= vcnt[c] + 8'd1;
          OP_VEND: if (vcnt[c] != 8'd0) vcnt[c] <= vcnt[c] - 8'd1;
          OP_LIMIT: vlim[c] <= it.new_limit;
          default: ;
        endcase
      end
      if (cmd.tick_mul) begin
        fade_on <= (flen[ki] != 16'd0) && (elap[ki] < flen[ki]);
        neg <= tgt[ki] < base[ki];
        prod <= (tgt[ki] < base[ki] ? 32'(base[ki] - tgt[ki]) : 32'(tgt[ki] - base[ki]))
                * 32'(e1);
      end
      eff_pend <= cmd.tick_eff;
      if (cmd.tick_eff) begin
        eidx <= ki;
        if (fade_on) begin
          elap[ki] <= e1;
          if (fdone) begin
            base[ki] <= tgt[ki];
            flen[ki] <= 16'd0;
          end else begin
            base[ki] <= (nb > 17'(UNITY)) ? UNITY : nb[15:0];
          end
        end
      end
      if (eff_pend) begin
        if (muted[eidx] || (soloed != '0 && !soloed[eidx])) eff[eidx] <= 16'd0;
        else eff[eidx] <= (gprod[31:15] > 17'(UNITY)) ? UNITY : gprod[30:15];
      end
      if (cmd.sum_step) begin
        if (idx == 5'd0) total <= 12'(vcnt[ki]);
        else total <= total + 12'(vcnt[ki]);
      end
    end
  end

  always_comb begin
    out_data.out_category = ki;
    out_data.effective_gain = eff[ki];
    out_data.base_gain = base[ki];
    out_data.voices_active = vcnt[ki];
    out_data.granted = grant && (it.operation == OP_ADMIT) && (c == ki);
    out_data.total_voices = total;
    out_data.solo_active = (soloed != '0);
    out_data.last = sts.idx_last;
  end
endmodule

FILE: sv/acg_ctrl.sv
// sequencer for operations, tick walk, voice sum and result beats
// depends on acg_pkg
`timescale 1ns / 1ps
module acg_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output acg_pkg::cmd_t cmd,
  input  acg_pkg::sts_t sts
);
  import acg_pkg::*;
  state_t state, state_next;
  logic   wait1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wait1 <= 1'b0;
    end else begin
      state <= state_next;
      wait1 <= (state == S_TMUL);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_OP;
      S_OP: state_next = sts.is_tick ? S_TMUL : S_SUM;
      S_TMUL: state_next = S_TDIV;
      S_TDIV: if (!sts.div_busy && !wait1) state_next = S_TEFF;
      S_TEFF: state_next = sts.idx_last ? S_SUM : S_TMUL;
      S_SUM: if (sts.idx_last) state_next = S_EMIT;
      S_EMIT: if (out_ready && sts.idx_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = (state == S_IDLE);
    out_valid = (state == S_EMIT);
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        cmd.clr_idx = 1'b1;
      end
      S_OP: begin
        cmd.do_op = 1'b1;
        cmd.clr_idx = 1'b1;
      end
      S_TMUL: cmd.tick_mul = 1'b1;
      S_TDIV: cmd.div_start = wait1;
      S_TEFF: begin
        cmd.tick_eff = 1'b1;
        cmd.clr_idx = sts.idx_last;
        cmd.inc_idx = !sts.idx_last;
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        cmd.clr_idx = sts.idx_last;
        cmd.inc_idx = !sts.idx_last;
      end
      S_EMIT: begin
        cmd.emit = out_ready;
        cmd.inc_idx = out_ready && !sts.idx_last;
      end
      default: ;
    endcase
  end
endmodule

FILE: sv/audio_category_gain_and_voice_admit_unit.sv
// top level of the category gain and voice admission unit
// depends on acg_pkg, acg_ctrl, acg_datapath
//
// channel  dir  beat
// in       in   one operation
// out      out  one category report, NUM_CATEGORIES beats per operation
// cfg      in   one register write
//
// a tick walks each category through the multiply, the bit-serial fade divider and the
// gain update, then sums the voices of all categories; other operations go to the voice sum.
// results go out one per cycle while out_ready is high; stalls hold the beat.
// reset restores the whole table at once; cfg is always ready.
`timescale 1ns / 1ps
module audio_category_gain_and_voice_admit_unit #(
  parameter int NUM_CATEGORIES = acg_pkg::NUM_CATEGORIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  acg_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output acg_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data
);
  import acg_pkg::*;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  acg_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

  acg_datapath #(.NUM_CATEGORIES(NUM_CATEGORIES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .in_data(in_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_data(out_data)
  );
endmodule

FILE: sv/acg_checker.sv
// port-level checks for the category gain unit, bound to the top level
// depends on acg_pkg and the macros header
`timescale 1ns / 1ps
`include "audio_category_gain_and_voice_admit_unit_macros.svh"
module acg_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input acg_pkg::out_t out_data
);
  import acg_pkg::*;
  `ACG_ASSERT_IMP(no_overlap, clk, rst, out_valid, !in_ready, "input taken during results")
  `ACG_ASSERT_NEXT(out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "stalled beat changed")
  `ACG_ASSERT_NEXT(last_ends, clk, rst, out_valid && out_ready && out_data.last, !out_valid, "beat after last")
  `ACG_ASSERT_IMP(gain_range, clk, rst, out_valid, out_data.effective_gain <= UNITY && out_data.base_gain <= UNITY, "gain above unity")
endmodule

bind audio_category_gain_and_voice_admit_unit acg_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
